### hdl/tst_pkg.sv
// Shared types, constants and helpers for the timer slot table.
// No dependencies; imported by every module of the block.
`default_nettype none

package tst_pkg;

  // Table size and time width (unsigned 16.16 seconds)
  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  // Request opcodes; the fourth code has no meaning
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_REG   = 2'd1,
    FUNC_DEREG = 2'd2
  } func_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_FIRED     = 3'd0,
    KIND_REGISTERED = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_REMOVED   = 3'd3,
    KIND_NOT_FOUND = 3'd4,
    KIND_DONE      = 3'd5
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch request fields
    logic tick_start;  // advance clock (clear it if no slot is live), prime trigger of slot 0
    logic scan_adv;    // move to next slot, prime its trigger
    logic fire;        // report current slot and retire or restart it
    logic emit_done;   // report end of tick
    logic do_reg;      // place a new timer
    logic do_dereg;    // free a slot
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic any_valid;
    logic cur_valid;
    logic cur_fire;
    logic idx_last;
    logic out_free;
  } sts_t;

  // Saturating time add
  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/tst_ctrl.sv
// Sequencer of the timer slot table: request decode and slot scan control.
// Depends on tst_pkg.
`default_nettype none

module tst_ctrl
  import tst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [1:0] func_i,
  input  wire sts_t       sts_i,
  output      cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_SCAN,
    S_DONE,
    S_REG,
    S_DEREG
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          unique case (func_e'(func_i))
            FUNC_TICK:  state_d = S_TICK;
            FUNC_REG:   state_d = S_REG;
            FUNC_DEREG: state_d = S_DEREG;
            default:    state_d = S_IDLE;  // unused opcode: dropped
          endcase
        end
      end
      S_TICK: begin
        cmd_o.tick_start = 1'b1;
        state_d = sts_i.any_valid ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        // hold on an expired slot until the result register frees up
        if (!(sts_i.cur_valid && sts_i.cur_fire && !sts_i.out_free)) begin
          cmd_o.fire     = sts_i.cur_valid && sts_i.cur_fire;
          cmd_o.scan_adv = 1'b1;
          if (sts_i.idx_last) state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_REG: begin
        if (sts_i.out_free) begin
          cmd_o.do_reg = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DEREG: begin
        if (sts_i.out_free) begin
          cmd_o.do_dereg = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result loads never collide and only happen into a free result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.fire, cmd_o.emit_done, cmd_o.do_reg, cmd_o.do_dereg}))
    else $error("tst_ctrl: more than one result load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fire || cmd_o.emit_done || cmd_o.do_reg || cmd_o.do_dereg) |-> sts_i.out_free)
    else $error("tst_ctrl: result load while output is blocked");

  // A tick always ends with its done transaction before the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.idx_last && cmd_o.scan_adv) |=> (state_q == S_DONE))
    else $error("tst_ctrl: scan did not close with done");

endmodule

`default_nettype wire

### hdl/tst_dp.sv
// Datapath of the timer slot table: slot store, running clock, trigger
// arithmetic and the result register. Depends on tst_pkg.
`default_nettype none

module tst_dp
  import tst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output      sts_t        sts_o,
  input  wire logic [31:0] delta_time_i,
  input  wire logic [31:0] period_i,
  input  wire logic        repeating_i,
  input  wire logic [3:0]  slot_index_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  kind_o,
  output      logic [3:0]  slot_number_o,
  output      logic [31:0] lateness_o,
  output      logic        last_o
);

  // Slot store
  logic [SLOTS-1:0] valid_q;
  logic [SLOTS-1:0] repeat_q;
  time_t            start_q  [SLOTS];
  time_t            period_q [SLOTS];

  // Clock, scan pointer, primed trigger, captured request
  time_t      now_q;
  slot_t      idx_q;
  slot_t      idx_nx;
  time_t      trig_q;
  time_t      delta_q;
  time_t      per_q;
  logic       rep_q;
  logic [3:0] sidx_q;

  // Result register
  logic        out_valid_q;
  kind_e       kind_q;
  logic [3:0]  slot_num_q;
  logic [31:0] late_q;
  logic        last_q;

  logic  out_free;
  logic  all_full;
  slot_t free_idx;
  logic  dereg_hit;
  slot_t sidx_s;

  assign idx_nx   = idx_q + 1'b1;
  assign sidx_s   = SLOT_W'(sidx_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign all_full = &valid_q;
  assign dereg_hit = (32'(sidx_q) < SLOTS) && valid_q[sidx_s];

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = SLOT_W'(i);
    end
  end

  assign sts_o.any_valid = |valid_q;
  assign sts_o.cur_valid = valid_q[idx_q];
  assign sts_o.cur_fire  = (now_q >= trig_q);
  assign sts_o.idx_last  = (idx_q == SLOT_W'(SLOTS - 1));
  assign sts_o.out_free  = out_free;

  // Control state: valid bits, clock, scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      now_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.tick_start) begin
        now_q <= sts_o.any_valid ? sat_add(now_q, delta_q) : '0;
        idx_q <= '0;
      end
      if (cmd_i.scan_adv) idx_q <= idx_nx;
      if (cmd_i.fire && !repeat_q[idx_q]) valid_q[idx_q] <= 1'b0;
      if (cmd_i.do_reg && !all_full) valid_q[free_idx] <= 1'b1;
      if (cmd_i.do_dereg && dereg_hit) valid_q[sidx_s] <= 1'b0;
    end
  end

  // Payload state: slot contents, captured fields, primed trigger
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      delta_q <= TIME_BITS'(delta_time_i);
      per_q   <= TIME_BITS'(period_i);
      rep_q   <= repeating_i;
      sidx_q  <= slot_index_i;
    end
    if (cmd_i.tick_start) trig_q <= sat_add(start_q[0], period_q[0]);
    if (cmd_i.scan_adv)   trig_q <= sat_add(start_q[idx_nx], period_q[idx_nx]);
    // repeating timer restarts at its trigger time
    if (cmd_i.fire && repeat_q[idx_q]) start_q[idx_q] <= trig_q;
    if (cmd_i.do_reg && !all_full) begin
      start_q[free_idx]  <= now_q;
      period_q[free_idx] <= per_q;
      repeat_q[free_idx] <= rep_q;
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fire || cmd_i.emit_done || cmd_i.do_reg || cmd_i.do_dereg) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.fire) begin
      kind_q     <= KIND_FIRED;
      slot_num_q <= 4'(idx_q);
      late_q     <= 32'(now_q - trig_q);
      last_q     <= 1'b0;
    end else if (cmd_i.emit_done) begin
      kind_q     <= KIND_DONE;
      slot_num_q <= '0;
      late_q     <= '0;
      last_q     <= 1'b1;
    end else if (cmd_i.do_reg) begin
      kind_q     <= all_full ? KIND_FULL : KIND_REGISTERED;
      slot_num_q <= all_full ? 4'd0 : 4'(free_idx);
      late_q     <= '0;
      last_q     <= 1'b1;
    end else if (cmd_i.do_dereg) begin
      kind_q     <= dereg_hit ? KIND_REMOVED : KIND_NOT_FOUND;
      slot_num_q <= sidx_q;
      late_q     <= '0;
      last_q     <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign slot_number_o = slot_num_q;
  assign lateness_o    = late_q;
  assign last_o        = last_q;

  // Saturating clock never runs backward on a tick with live timers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick_start && sts_o.any_valid) |=> (now_q >= $past(now_q)))
    else $error("tst_dp: clock went backward");

  // A successful register leaves the chosen slot live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_reg && !all_full) |=> valid_q[$past(free_idx)])
    else $error("tst_dp: registered slot not marked live");

  // A stalled result transaction holds valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      (out_valid_q && $stable({kind_q, slot_num_q, late_q, last_q})))
    else $error("tst_dp: stalled result changed");

endmodule

`default_nettype wire

### hdl/timer_slot_table_unit.sv
// Timer slot table: one request at a time; results leave through a registered
// output. A register or deregister request is captured, and its result loads
// once the output is free; a tick advances the clock and scans one slot per
// cycle, holding on an expired slot while the output stalls (an empty table
// skips the scan), then reports done. Reset (async, active low) frees all
// slots and clears the clock. Depends on tst_pkg, tst_ctrl, tst_dp.
`default_nettype none

module timer_slot_table_unit
  import tst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] delta_time_i,
  input  wire logic [31:0] period_i,
  input  wire logic        repeating_i,
  input  wire logic [3:0]  slot_index_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  kind_o,
  output      logic [3:0]  slot_number_o,
  output      logic [31:0] lateness_o,
  output      logic        last_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  tst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot store and arithmetic
  tst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .delta_time_i  (delta_time_i),
    .period_i      (period_i),
    .repeating_i   (repeating_i),
    .slot_index_i  (slot_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .slot_number_o (slot_number_o),
    .lateness_o    (lateness_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
